FILE: src/arpc_pkg.sv
// arpc_pkg: shared types and constants of the address cache.
// Used by arpc_store and arp_cache_oldest_replace; depends on nothing.
package arpc_pkg;

    localparam int unsigned ENTRIES = 64;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned IP_W    = 32;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned SLOT_W  = 6;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    ip;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } store_wr_t;

endpackage

FILE: src/arpc_store.sv
// arpc_store: entry memory with one read and one write port, registered read data.
// Per-entry valid bits make unwritten entries read as zero. Depends on arpc_pkg.
module arpc_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [arpc_pkg::IDX_W-1:0]    rd_addr,
    output arpc_pkg::entry_t              rd_data,
    input  arpc_pkg::store_wr_t           wr
);

    arpc_pkg::entry_t                 mem [arpc_pkg::ENTRIES];
    arpc_pkg::entry_t                 rd_q_reg;
    logic                             rd_vld_reg;
    logic [arpc_pkg::ENTRIES-1:0]     vld_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // an entry never written reads as its reset value
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

FILE: src/arp_cache_oldest_replace.sv
// arp_cache_oldest_replace: IPv4-to-MAC address cache, oldest-entry replacement.
// Top level; instantiates arpc_store and uses arpc_pkg.
//
// One transaction on the s_ side is either a lookup (s_tuser = 0) or an insert
// (s_tuser = 1), and it yields exactly one transaction on the m_ side. Every
// request is served by one sweep: the single read port of the entry memory is
// swept once over all entries, one entry a cycle with a registered read, and the
// finishing state writes back an insert and loads the result register once the
// m_ side can take it. A lookup returns the MAC of the lowest
// occupied entry (stamp not zero) with matching IP, or a miss with zero MAC and
// slot. An insert takes the first free entry, else the lowest entry with the
// smallest stamp, and always reports a hit with the stored MAC. Duplicate IPs are
// not checked. An insert at tick zero leaves the entry free. The cache is empty
// straight after reset; no clearing pass is needed. A new request is taken while
// a finished result still waits on the m_ side.
module arp_cache_oldest_replace (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32], now_tick[111:80]
    input  logic [0:0]   s_tuser,   // op[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // mac_found[47:0], slot_index[53:48], zero pad
    output logic [0:0]   m_tuser    // hit[0]
);

    localparam int unsigned CNT_W = arpc_pkg::IDX_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;

    // request held for the whole sweep
    logic                             op_reg;
    logic [arpc_pkg::IP_W-1:0]        ip_reg;
    logic [arpc_pkg::MAC_W-1:0]       mac_reg;
    logic [arpc_pkg::STAMP_W-1:0]     tick_reg;

    // sweep control
    logic [CNT_W-1:0]                 issue_cnt_reg;
    logic                             rd_pend_reg;
    logic [arpc_pkg::IDX_W-1:0]       rd_idx_reg;
    logic                             rd_en;
    logic [arpc_pkg::IDX_W-1:0]       rd_addr;
    arpc_pkg::entry_t                 rd_data;

    // lookup tracking
    logic                             found_reg;
    logic [arpc_pkg::MAC_W-1:0]       found_mac_reg;
    logic [arpc_pkg::IDX_W-1:0]       found_idx_reg;

    // victim tracking
    logic                             free_found_reg;
    logic [arpc_pkg::STAMP_W-1:0]     best_stamp_reg;
    logic [arpc_pkg::IDX_W-1:0]       victim_reg;

    // result register
    logic                             m_valid_reg;
    logic                             m_hit_reg;
    logic [arpc_pkg::MAC_W-1:0]       m_mac_reg;
    logic [arpc_pkg::SLOT_W-1:0]      m_slot_reg;

    logic                             s_accept;
    logic                             occupied;
    logic                             last_data;
    logic                             out_load;
    arpc_pkg::store_wr_t              wr;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign rd_en     = (state_reg == ST_SCAN) &&
                       (issue_cnt_reg != CNT_W'(arpc_pkg::ENTRIES));
    assign rd_addr   = issue_cnt_reg[arpc_pkg::IDX_W-1:0];
    assign occupied  = (rd_data.stamp != '0);
    assign last_data = rd_pend_reg && (rd_idx_reg == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1));
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    // write back an insert as the result is loaded
    always_comb begin
        wr.en         = out_load && (op_reg == arpc_pkg::OP_INSERT);
        wr.addr       = victim_reg;
        wr.data.ip    = ip_reg;
        wr.data.mac   = mac_reg;
        wr.data.stamp = tick_reg;
    end

    arpc_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        issue_cnt_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                    end
                    if (last_data) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload: latch the request, track the sweep, load the result
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr;
        if (s_accept) begin
            op_reg         <= s_tuser[0];
            ip_reg         <= s_tdata[31:0];
            mac_reg        <= s_tdata[79:32];
            tick_reg       <= s_tdata[111:80];
            found_reg      <= 1'b0;
            found_mac_reg  <= '0;
            found_idx_reg  <= '0;
            free_found_reg <= 1'b0;
            best_stamp_reg <= arpc_pkg::STAMP_MAX;
            victim_reg     <= '0;
        end else if (rd_pend_reg) begin
            // lowest occupied matching entry wins
            if (!found_reg && occupied && (rd_data.ip == ip_reg)) begin
                found_reg     <= 1'b1;
                found_mac_reg <= rd_data.mac;
                found_idx_reg <= rd_idx_reg;
            end
            // first free entry, else lowest entry with the strictly smallest stamp
            if (!free_found_reg) begin
                if (!occupied) begin
                    free_found_reg <= 1'b1;
                    victim_reg     <= rd_idx_reg;
                end else if (rd_data.stamp < best_stamp_reg) begin
                    best_stamp_reg <= rd_data.stamp;
                    victim_reg     <= rd_idx_reg;
                end
            end
        end
        if (out_load) begin
            if (op_reg == arpc_pkg::OP_INSERT) begin
                m_hit_reg  <= 1'b1;
                m_mac_reg  <= mac_reg;
                m_slot_reg <= arpc_pkg::SLOT_W'(victim_reg);
            end else begin
                m_hit_reg  <= found_reg;
                m_mac_reg  <= found_mac_reg;
                m_slot_reg <= arpc_pkg::SLOT_W'(found_idx_reg);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {2'b00, m_slot_reg, m_mac_reg};

    // a miss carries zero MAC and zero slot
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss result carries nonzero payload");

    // no second request is taken while one is being swept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request accepted during a sweep");

    // a new result appears only from the finishing cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (rd_pend_reg == 1'b0))
        else $error("result loaded while the sweep still has reads in flight");

    // the sweep ends exactly after the last entry's data
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && last_data) |->
            (issue_cnt_reg == CNT_W'(arpc_pkg::ENTRIES)))
        else $error("sweep ended before all entries were read");

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for arp_cache_oldest_replace.
// Keeps its own copy of the cache and checks every m_ transaction against it, or against a typed row's answer.
// Depends on arpc_pkg and the arp_cache_oldest_replace RTL only.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 2000;   // cycles without any transaction
    localparam int TAIL_CYCLES  = arpc_pkg::ENTRIES + 16;
    localparam int REPORT_MAX   = 10;

    // One result as the block reports it.
    typedef struct packed {
        logic                        hit;
        logic [arpc_pkg::MAC_W-1:0]  mac;
        logic [arpc_pkg::SLOT_W-1:0] slot;
    } cache_reply_t;

    // One row of the directed table; typed rows carry their own answer.
    typedef struct packed {
        logic                         op;
        logic [arpc_pkg::IP_W-1:0]    ip;
        logic [arpc_pkg::MAC_W-1:0]   mac;
        logic [arpc_pkg::STAMP_W-1:0] tick;
        logic                         typed;
        cache_reply_t                 reply;
    } directed_row_t;

    typedef enum int {
        BURST_TRAFFIC,
        BURST_SWEEP,
        BURST_NOISE,
        BURST_EXTREME,
        BURST_PAUSE
    } burst_kind_t;

    localparam int DIRECTED_ROWS = 18;

    // Directed table: the empty cache, the field extremes, a tick-zero insert that
    // leaves its entry free, a duplicate IP and the lowest-index rule on lookup.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{arpc_pkg::OP_LOOKUP, 32'h0000_0000, 48'h0, 32'h0, 1'b1, '{1'b0, 48'h0, 6'd0}},
        '{arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 48'h0, 6'd0}},
        '{arpc_pkg::OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 48'hFFFF_FFFF_FFFF, 6'd0}},
        '{arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0, 1'b1,
          '{1'b1, 48'hFFFF_FFFF_FFFF, 6'd0}},
        '{arpc_pkg::OP_INSERT, 32'h0000_0000, 48'h0, 32'h0, 1'b1, '{1'b1, 48'h0, 6'd1}},
        '{arpc_pkg::OP_LOOKUP, 32'h0000_0000, 48'h0, 32'h0, 1'b1, '{1'b0, 48'h0, 6'd0}},
        '{arpc_pkg::OP_INSERT, 32'h0000_0000, 48'h1, 32'h1, 1'b1, '{1'b1, 48'h1, 6'd1}},
        '{arpc_pkg::OP_LOOKUP, 32'h0000_0000, 48'h0, 32'h0, 1'b1, '{1'b1, 48'h1, 6'd1}},
        '{arpc_pkg::OP_INSERT, 32'hFFFF_FFFF, 48'h5555_5555_5555, 32'h2, 1'b1,
          '{1'b1, 48'h5555_5555_5555, 6'd2}},
        '{arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0, 1'b1,
          '{1'b1, 48'hFFFF_FFFF_FFFF, 6'd0}},
        '{arpc_pkg::OP_INSERT, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b1,
          '{1'b1, 48'hAAAA_AAAA_AAAA, 6'd3}},
        '{arpc_pkg::OP_INSERT, 32'h5555_5555, 48'h8000_0000_0000, 32'h8000_0000, 1'b0,
          '0},
        '{arpc_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 48'h0, 32'h0, 1'b0, '0},
        '{arpc_pkg::OP_LOOKUP, 32'h5555_5555, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0,
          '0},
        '{arpc_pkg::OP_LOOKUP, 32'h0000_0001, 48'h0, 32'h0, 1'b0, '0},
        '{arpc_pkg::OP_INSERT, 32'hC0A8_0001, 48'h0200_5E00_0001, 32'h7FFF_FFFF, 1'b0,
          '0},
        '{arpc_pkg::OP_LOOKUP, 32'hC0A8_0001, 48'h0, 32'h0, 1'b0, '0},
        '{arpc_pkg::OP_LOOKUP, 32'h8000_0000, 48'h0, 32'h0, 1'b0, '0}
    };

    // Clock, reset and the two stream channels; every input starts known.
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;   // ip_addr[31:0], mac_addr[79:32], now_tick[111:80]
    logic [0:0]   s_tuser  = '0;   // op[0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;         // mac_found[47:0], slot_index[53:48], zero pad
    logic [0:0]   m_tuser;         // hit[0]

    // Shadow copy of the cache, updated as each request is accepted.
    logic [arpc_pkg::IP_W-1:0]    cache_ip    [arpc_pkg::ENTRIES];
    logic [arpc_pkg::MAC_W-1:0]   cache_mac   [arpc_pkg::ENTRIES];
    logic [arpc_pkg::STAMP_W-1:0] cache_stamp [arpc_pkg::ENTRIES];

    cache_reply_t                 pending_replies [$];
    logic [arpc_pkg::IP_W-1:0]    ip_pool [8];
    logic [arpc_pkg::STAMP_W-1:0] tick_now = 32'd1000;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    int items_sent     = 0;
    int replies_seen   = 0;
    int mismatches     = 0;
    int lookups        = 0;
    int lookup_hits    = 0;
    int inserts        = 0;
    int full_evictions = 0;
    int idle_cycles    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    arp_cache_oldest_replace uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Work out the reply to one request and apply it to the shadow cache.
    // Insert: first free entry, else lowest index among the smallest stamps.
    // Lookup: lowest-index occupied entry with a matching IP.
    function automatic cache_reply_t predict_reply(
        input logic                         op,
        input logic [arpc_pkg::IP_W-1:0]    ip,
        input logic [arpc_pkg::MAC_W-1:0]   mac,
        input logic [arpc_pkg::STAMP_W-1:0] tick);
        cache_reply_t                 r;
        int                           victim;
        logic [arpc_pkg::STAMP_W-1:0] oldest;
        bit                           found;
        r      = '0;
        victim = 0;
        oldest = arpc_pkg::STAMP_MAX;
        found  = 1'b0;
        if (op == arpc_pkg::OP_INSERT) begin
            for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
                if (!found) begin
                    if (cache_stamp[i] == '0) begin
                        victim = i;
                        found  = 1'b1;
                    end else if (cache_stamp[i] < oldest) begin
                        oldest = cache_stamp[i];
                        victim = i;
                    end
                end
            end
            inserts++;
            if (!found)
                full_evictions++;
            cache_ip[victim]    = ip;
            cache_mac[victim]   = mac;
            cache_stamp[victim] = tick;
            r.hit  = 1'b1;
            r.mac  = mac;
            r.slot = arpc_pkg::SLOT_W'(victim);
        end else begin
            lookups++;
            for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
                if (!found && cache_stamp[i] != '0 && cache_ip[i] == ip) begin
                    found  = 1'b1;
                    r.hit  = 1'b1;
                    r.mac  = cache_mac[i];
                    r.slot = arpc_pkg::SLOT_W'(i);
                end
            end
            if (found)
                lookup_hits++;
        end
        return r;
    endfunction

    // Offer one request on the s_ side after a random gap; on acceptance queue
    // the expected reply (the typed one if the row carries it).
    task automatic offer_request(input logic op, input logic [arpc_pkg::IP_W-1:0] ip,
                                 input logic [arpc_pkg::MAC_W-1:0] mac,
                                 input logic [arpc_pkg::STAMP_W-1:0] tick,
                                 input logic typed, input cache_reply_t typed_reply);
        int           gap;
        cache_reply_t predicted;
        gap = src_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tick, mac, ip};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_reply(op, ip, mac, tick);
        pending_replies.push_back(typed ? typed_reply : predicted);
        items_sent++;
    endtask

    // Hold off the sender until every outstanding reply has come back.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    // Mixed lookups and inserts with mostly rising ticks, small steps so that
    // stamps tie, and lookups aimed mostly at addresses the cache holds.
    task automatic traffic_item();
        logic                         op;
        logic [arpc_pkg::IP_W-1:0]    ip;
        logic [arpc_pkg::STAMP_W-1:0] tick;
        int                           pick;
        op   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (op == arpc_pkg::OP_INSERT) begin
            ip = (pick < 5) ? ip_pool[$urandom_range(0, 7)] : arpc_pkg::IP_W'($urandom());
            tick_now = tick_now + arpc_pkg::STAMP_W'($urandom_range(0, 2));
            tick = ($urandom_range(0, 15) == 0) ? '0 : tick_now;
        end else begin
            if (pick < 6)
                ip = cache_ip[$urandom_range(0, arpc_pkg::ENTRIES - 1)];
            else if (pick < 8)
                ip = ip_pool[$urandom_range(0, 7)];
            else
                ip = arpc_pkg::IP_W'($urandom());
            tick = arpc_pkg::STAMP_W'($urandom());
        end
        offer_request(op, ip, arpc_pkg::MAC_W'({$urandom(), $urandom()}), tick, 1'b0, '0);
    endtask

    // Receiver: stall at random, take each reply and compare it with the
    // oldest expectation, field by field.
    initial begin
        int           gap;
        cache_reply_t want;
        cache_reply_t got;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = sink_idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.hit  = m_tuser[0];
            got.mac  = m_tdata[47:0];
            got.slot = m_tdata[53:48];
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected reply: hit=%0b mac=%012h slot=%0d",
                             $realtime, got.hit, got.mac, got.slot);
            end else begin
                want = pending_replies.pop_front();
                if (got.hit != want.hit || got.mac != want.mac || got.slot != want.slot)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] reply %0d: hit %0b/%0b mac %012h/%012h slot %0d/%0d",
                                 $realtime, replies_seen, want.hit, got.hit,
                                 want.mac, got.mac, want.slot, got.slot);
                end
            end
        end
    end

    // Watchdog: give up when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
                         IDLE_LIMIT, pending_replies.size());
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Stimulus: reset, the directed table, then random bursts.
    initial begin
        burst_kind_t                  kind;
        int                           burst;
        int                           len;
        int                           pick;
        logic [arpc_pkg::STAMP_W-1:0] sweep_tick;
        for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
            cache_ip[i]    = '0;
            cache_mac[i]   = '0;
            cache_stamp[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; typed rows check the answer read off by hand.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer_request(directed_rows[r].op, directed_rows[r].ip, directed_rows[r].mac,
                          directed_rows[r].tick, directed_rows[r].typed,
                          directed_rows[r].reply);
        drain_replies();

        for (int i = 0; i < 8; i++)
            ip_pool[i] = arpc_pkg::IP_W'($urandom());

        // Random bursts. The first is always a sweep at the top stamp: it fills the
        // cache and then replaces through it, so every stamp ends up equal and
        // the inserts that follow must take entry 0.
        burst = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (burst == 0 || pick == 0)
                kind = BURST_SWEEP;
            else if (pick < 6)
                kind = BURST_TRAFFIC;
            else if (pick == 6)
                kind = BURST_NOISE;
            else if (pick == 7)
                kind = BURST_EXTREME;
            else
                kind = BURST_PAUSE;
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            case (kind)
                BURST_SWEEP: begin
                    tick_now = tick_now + 1;
                    sweep_tick = (burst == 0) ? arpc_pkg::STAMP_MAX : tick_now;
                    repeat (arpc_pkg::ENTRIES + 4)
                        offer_request(arpc_pkg::OP_INSERT, arpc_pkg::IP_W'($urandom()),
                                      arpc_pkg::MAC_W'({$urandom(), $urandom()}),
                                      sweep_tick, 1'b0, '0);
                    repeat (2)
                        offer_request(arpc_pkg::OP_LOOKUP,
                                      cache_ip[$urandom_range(0, arpc_pkg::ENTRIES - 1)],
                                      '0, '0, 1'b0, '0);
                end
                BURST_TRAFFIC: begin
                    len = $urandom_range(10, 40);
                    repeat (len) traffic_item();
                end
                BURST_NOISE: begin
                    // Anything goes, ticks anywhere in the 32-bit range.
                    len = $urandom_range(5, 20);
                    repeat (len)
                        offer_request(1'($urandom_range(0, 1)), arpc_pkg::IP_W'($urandom()),
                                      arpc_pkg::MAC_W'({$urandom(), $urandom()}),
                                      arpc_pkg::STAMP_W'($urandom()), 1'b0, '0);
                end
                BURST_EXTREME: begin
                    // Stamps at the top of the range and at zero, mixed with lookups that probe them.
                    repeat ($urandom_range(4, 10)) begin
                        pick = $urandom_range(0, 3);
                        if (pick == 0)
                            offer_request(arpc_pkg::OP_INSERT, ip_pool[$urandom_range(0, 7)],
                                          arpc_pkg::MAC_W'({$urandom(), $urandom()}),
                                          arpc_pkg::STAMP_MAX, 1'b0, '0);
                        else if (pick == 1)
                            offer_request(arpc_pkg::OP_INSERT, ip_pool[$urandom_range(0, 7)],
                                          arpc_pkg::MAC_W'({$urandom(), $urandom()}), '0,
                                          1'b0, '0);
                        else
                            offer_request(arpc_pkg::OP_LOOKUP, ip_pool[$urandom_range(0, 7)],
                                          arpc_pkg::MAC_W'({$urandom(), $urandom()}),
                                          arpc_pkg::STAMP_W'($urandom()), 1'b0, '0);
                    end
                end
                default: begin
                    // Let the pipeline run dry, then resume with normal traffic.
                    drain_replies();
                    repeat (10) traffic_item();
                end
            endcase
            burst++;
        end

        // Wait out the last replies, then a little longer for strays.
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run: %0d requests, %0d lookups (%0d hits), %0d inserts (%0d into a full cache)",
                 items_sent, lookups, lookup_hits, inserts, full_evictions);
        $display("run: %0d replies checked, %0d mismatches", replies_seen, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
